[rtl/rmth_pkg.sv]
// Package: sizes and shared types for the running median block.
`timescale 1ns / 1ps
`default_nettype none
package rmth_pkg;
  localparam int HeapDepth = 512;
  localparam int AddrW = $clog2(HeapDepth);
  localparam int CntW = AddrW + 1;
  localparam int TotW = CntW + 1;
  localparam int DataW = 32;

  typedef logic [DataW-1:0] word_t;
  typedef logic [AddrW-1:0] addr_t;
  typedef logic [CntW-1:0] cnt_t;

  // Order key: a signed value with its sign bit flipped compares unsigned.
  function automatic word_t key_of(input word_t v);
    key_of = v ^ {1'b1, {(DataW-1){1'b0}}};
  endfunction
endpackage
`default_nettype wire

[rtl/rmth_heap.sv]
// One binary heap in a one-read one-write memory, with push and replace-top under a sequencer.
`timescale 1ns / 1ps
`default_nettype none
module rmth_heap (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           is_max,
  input  wire logic           push,     // start a push of din
  input  wire logic           repl,     // start a replace of the top by din
  input  wire rmth_pkg::word_t din,
  output rmth_pkg::word_t      top,      // entry 0, valid when count > 0
  output rmth_pkg::word_t      old_top,  // top before the last replace
  output rmth_pkg::cnt_t       count,
  output logic                busy
);
  import rmth_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UPRD = 3'd1;  // read parent
  localparam logic [2:0] S_UPCK = 3'd2;  // compare, write
  localparam logic [2:0] S_DNRL = 3'd3;  // read left child, or settle at a leaf
  localparam logic [2:0] S_DNRR = 3'd4;  // read right child
  localparam logic [2:0] S_DNCK = 3'd5;  // compare, write
  localparam logic [2:0] S_UPWR = 3'd6;  // settle the moving value at the root

  word_t mem [HeapDepth];
  word_t rdata;
  logic [2:0] state;
  addr_t pos, raddr;
  word_t val, lchild, top_r;
  logic rd_en, wr_en;
  addr_t waddr;
  word_t wdata;

  function automatic logic above(input logic mx, input word_t a, input word_t b);
    above = mx ? (key_of(a) > key_of(b)) : (key_of(a) < key_of(b));
  endfunction

  always_ff @(posedge clk) begin
    if (wr_en) mem[waddr] <= wdata;
    if (rd_en) rdata <= mem[raddr];
  end

  logic [AddrW:0] left_w;
  addr_t parent_w;
  logic has_right;
  logic no_child;
  word_t best_v;
  logic best_r;
  assign left_w = {pos, 1'b1};
  assign parent_w = addr_t'((pos - addr_t'(1)) >> 1);
  assign has_right = ({1'b0, left_w} + TotW'(1)) < {1'b0, count};
  assign no_child = (left_w >= count);
  always_comb begin
    best_r = has_right && above(is_max, rdata, lchild);
    best_v = best_r ? rdata : lchild;
  end

  always_comb begin
    rd_en = 1'b0; raddr = '0; wr_en = 1'b0; waddr = pos; wdata = val;
    unique case (state)
      S_IDLE: begin
        if (push) begin
          wr_en = 1'b1; waddr = addr_t'(count); wdata = din;
        end else if (repl) begin
          wr_en = 1'b1; waddr = '0; wdata = din;
        end
      end
      S_UPRD: begin rd_en = 1'b1; raddr = parent_w; end
      S_UPCK: begin
        if (above(is_max, val, rdata)) begin
          wr_en = 1'b1; waddr = pos; wdata = rdata;
        end else begin
          wr_en = 1'b1; waddr = pos; wdata = val;
        end
      end
      S_DNRL: begin
        rd_en = 1'b1; raddr = addr_t'(left_w);
        if (no_child) wr_en = 1'b1;
      end
      S_DNRR: begin rd_en = 1'b1; raddr = addr_t'(left_w + (AddrW+1)'(1)); end
      S_DNCK: begin
        wr_en = 1'b1; waddr = pos;
        wdata = above(is_max, best_v, val) ? best_v : val;
      end
      S_UPWR: wr_en = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (push) begin
            val <= din; pos <= addr_t'(count); count <= count + cnt_t'(1);
            state <= (count == '0) ? S_IDLE : S_UPRD;
            if (count == '0) top_r <= din;
          end else if (repl) begin
            old_top <= top_r; val <= din; pos <= '0; top_r <= din;
            state <= S_DNRL;
          end
        end
        S_UPRD: state <= S_UPCK;
        S_UPCK: begin
          if (above(is_max, val, rdata)) begin
            pos <= parent_w;
            if (parent_w == '0) begin
              top_r <= val; state <= S_UPWR;
            end else state <= S_UPRD;
          end else state <= S_IDLE;
        end
        S_UPWR: state <= S_IDLE;
        S_DNRL: begin
          if (no_child) state <= S_IDLE;
          else state <= S_DNRR;
        end
        S_DNRR: begin lchild <= rdata; state <= S_DNCK; end
        S_DNCK: begin
          if (above(is_max, best_v, val)) begin
            if (pos == '0) top_r <= best_v;
            pos <= best_r ? addr_t'(left_w + (AddrW+1)'(1)) : addr_t'(left_w);
            state <= S_DNRL;
          end else state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The moving value stays in val; each step moves one neighbor into the hole,
  // and the value is written where it settles.
  assign top = top_r;
  assign busy = (state != S_IDLE);
endmodule
`default_nettype wire

[rtl/running_median_two_heaps_top.sv]
// Top level: running median of signed samples over two heaps.
//
// Usage: s_axis carries one signed 32-bit sample per transfer. For every
// accepted sample one result transfer leaves on m_axis: the median doubled
// (33 bits, signed), the number of samples held, and a refused flag when
// the store (2 x 512 samples) was full and the sample was dropped.
// Flow: an insert either pushes into one heap, or replaces the top of
// one heap and pushes the old top into the other. A sift-up level reads
// the parent, then compares and writes; a sink level reads the left and
// the right child, then compares and writes; both use each heap's one
// read and one write port. With 512 entries either sift runs up to 9
// levels. s_tready is low while an item is in work or its result is held
// unread, so the block takes no new sample before the last result has
// been transferred. A stalled receiver holds the result in the output
// register; the next sample is taken only after that transfer. Reset
// clears the heap counts and the output valid; heap memories are not
// cleared, and only entries below the counts are used.
`timescale 1ns / 1ps
`default_nettype none
module running_median_two_heaps_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] sample
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // [32:0] median_times_two, [43:33] stored_count, 0 pad
  output logic             m_tuser    // refused
);
  import rmth_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WAIT1 = 3'd1;  // first heap operation
  localparam logic [2:0] S_XFER = 3'd2;   // push old top into other heap
  localparam logic [2:0] S_WAIT2 = 3'd3;
  localparam logic [2:0] S_OUT = 3'd4;

  logic [2:0] state;
  logic lo_push, lo_repl, up_push, up_repl, lo_busy, up_busy;
  word_t lo_din, up_din, lo_top, up_top, lo_old, up_old;
  cnt_t lo_cnt, up_cnt;
  logic to_lower;  // second step pushes into lower heap

  rmth_heap u_lo (.clk, .rst, .is_max(1'b1), .push(lo_push), .repl(lo_repl), .din(lo_din),
    .top(lo_top), .old_top(lo_old), .count(lo_cnt), .busy(lo_busy));
  rmth_heap u_up (.clk, .rst, .is_max(1'b0), .push(up_push), .repl(up_repl), .din(up_din),
    .top(up_top), .old_top(up_old), .count(up_cnt), .busy(up_busy));

  logic [TotW-1:0] total;
  logic full, accept;
  assign total = TotW'(lo_cnt) + TotW'(up_cnt);
  assign full = (total == TotW'(2 * HeapDepth));
  assign s_tready = (state == S_IDLE) && !m_tvalid;
  assign accept = s_tvalid && s_tready;

  // Path choice on acceptance
  logic eq_cnt, swap;
  assign eq_cnt = (lo_cnt == up_cnt);
  always_comb begin
    if (eq_cnt) swap = (up_cnt != '0) && (key_of(s_tdata) > key_of(up_top));
    else swap = key_of(s_tdata) < key_of(lo_top);
  end

  always_comb begin
    lo_push = 1'b0; lo_repl = 1'b0; up_push = 1'b0; up_repl = 1'b0;
    lo_din = s_tdata; up_din = s_tdata;
    if (accept && !full) begin
      if (eq_cnt) begin
        if (swap) up_repl = 1'b1; else lo_push = 1'b1;
      end else begin
        if (swap) lo_repl = 1'b1; else up_push = 1'b1;
      end
    end else if (state == S_XFER) begin
      if (to_lower) begin lo_push = 1'b1; lo_din = up_old; end
      else begin up_push = 1'b1; up_din = lo_old; end
    end
  end

  logic refused;
  logic [DataW:0] med;
  always_comb begin
    if (lo_cnt == '0) med = '0;
    else if (total[0] || up_cnt == '0) med = {lo_top, 1'b0};
    else med = {lo_top[DataW-1], lo_top} + {up_top[DataW-1], up_top};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: if (accept) begin
          refused <= full;
          to_lower <= eq_cnt;
          state <= full ? S_OUT : (swap ? S_WAIT1 : S_WAIT2);
        end
        S_WAIT1: if (!lo_busy && !up_busy) state <= S_XFER;
        S_XFER: state <= S_WAIT2;
        S_WAIT2: if (!lo_busy && !up_busy) state <= S_OUT;
        S_OUT: begin
          m_tvalid <= 1'b1;
          m_tdata <= {4'd0, 11'(total), med};
          m_tuser <= refused;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
